@@ hdl/assert_macros.svh @@
// ----------------------------------------------------------------------------
// assert_macros.svh
// concurrent assertion macros for the checker file
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property holds on every clock edge out of reset
`define ASSERT_ALWAYS(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// consequent holds in the cycle after the antecedent
`define ASSERT_NEXT(lbl, clk, rst_n, pre, post, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
        else $error(msg);

`endif

@@ hdl/rmdc_pkg.sv @@
// ----------------------------------------------------------------------------
// rmdc_pkg
// types and constants shared by the random mac distinct counter
// ----------------------------------------------------------------------------
`default_nettype none

package rmdc_pkg;

    // seen map geometry
    localparam int MAP_WORDS = 2048;
    localparam int MAP_AW    = $clog2(MAP_WORDS);
    localparam int WORD_W    = 32;
    localparam int BIT_AW    = $clog2(WORD_W);
    localparam int ID_W      = 16;

    // device list geometry
    localparam int LIST_DEPTH = 16;
    localparam int LIST_AW    = (LIST_DEPTH > 1) ? $clog2(LIST_DEPTH) : 1;
    localparam int CNT_W      = $clog2(LIST_DEPTH + 1);

    // field widths
    localparam int MAC_W    = 48;
    localparam int KIND_W   = 2;
    localparam int STR_W    = 8;
    localparam int TIME_W   = 32;
    localparam int IDX_W    = 4;
    localparam int TOT_W    = 16;
    localparam int SEEN_W   = 17;
    localparam int STORED_W = 5;
    localparam int INFO_W   = KIND_W + STR_W;

    // stream widths
    localparam int IN_DATA_W  = 96;
    localparam int IN_USER_W  = 4;
    localparam int OUT_DATA_W = 144;
    localparam int OUT_USER_W = 2;

    // configuration
    localparam int                CAP_W     = 5;
    localparam logic [CAP_W-1:0]  CAP_RESET = 5'd10;
    localparam int                APB_AW    = 3;
    localparam int                APB_DW    = 32;
    localparam logic              REG_LIST_CAPACITY = 1'b0;

    // locally administered flag: bit 1 of mac byte 0
    localparam int LOCAL_ADMIN_POS = 41;

    // sniff kinds that move a counter
    localparam logic [KIND_W-1:0] KIND_WIFI = 2'd0;
    localparam logic [KIND_W-1:0] KIND_BLE  = 2'd1;

    // input queue between front and back, power of two
    localparam int QUEUE_DEPTH = 2;
    localparam int QUEUE_AW    = $clog2(QUEUE_DEPTH);

    typedef enum logic [1:0] {
        OP_OBSERVE    = 2'd0,
        OP_CLEAR_MAP  = 2'd1,
        OP_CLEAR_LIST = 2'd2,
        OP_READ       = 2'd3
    } op_t;

    typedef enum logic [1:0] {
        ST_SWEEP,
        ST_IDLE,
        ST_LOOK,
        ST_DONE
    } state_t;

    // classified command
    typedef struct packed {
        op_t                 op;
        logic                local_admin;
        logic [MAP_AW-1:0]   word;
        logic [BIT_AW-1:0]   bit_pos;
        logic [MAC_W-1:0]    mac;
        logic [KIND_W-1:0]   kind;
        logic [STR_W-1:0]    strength;
        logic [TIME_W-1:0]   stamp;
        logic [IDX_W-1:0]    idx;
    } cmd_t;

    // queue head seen by the back end
    typedef struct packed {
        logic valid;
        cmd_t cmd;
    } q_head_t;

    // one result item
    typedef struct packed {
        logic                 is_new;
        logic [TOT_W-1:0]     wifi_total;
        logic [TOT_W-1:0]     ble_total;
        logic [SEEN_W-1:0]    seen_total;
        logic [STORED_W-1:0]  stored_total;
        logic                 entry_valid;
        logic [MAC_W-1:0]     entry_mac;
        logic [KIND_W-1:0]    entry_kind;
        logic [STR_W-1:0]     entry_strength;
        logic [TIME_W-1:0]    entry_time;
    } res_t;

endpackage

`default_nettype wire

@@ hdl/random_mac_distinct_counter.sv @@
// ----------------------------------------------------------------------------
// random_mac_distinct_counter
// counts distinct locally administered mac ids in a 64k-bit seen map
// ----------------------------------------------------------------------------
// usage
//   input items arrive on s_axis: tuser carries op and sniff kind, tdata the
//   mac, signal strength, time stamp and list entry index
//   every input item yields exactly one result item on m_axis
//   list_capacity is written through the apb port at byte address 0
// order of work
//   observe, clear list and read entry: pop in idle, the registered seen
//   map read and the read-modify-write of the looked up word in the lookup
//   state, then the output register; the next item is popped after that
//   clear seen map: the map is swept one word a cycle, all 2048 words
// reset
//   after reset all 2048 words of the seen map are swept clean; s_axis_tready
//   stays low meanwhile, configuration writes are taken as usual
// stall
//   a two-item queue takes new items while the output register waits on
//   m_axis_tready; once the queue is full s_axis_tready drops
// ----------------------------------------------------------------------------
`default_nettype none

module random_mac_distinct_counter (
    input  wire logic                            clk,
    input  wire logic                            rst_n,
    // input item stream
    input  wire logic                            s_axis_tvalid,
    output logic                                 s_axis_tready,
    // mac_addr, signal_strength, time_stamp, entry_index, zero pad
    input  wire logic [rmdc_pkg::IN_DATA_W-1:0]  s_axis_tdata,
    // op, sniff_kind
    input  wire logic [rmdc_pkg::IN_USER_W-1:0]  s_axis_tuser,
    // result item stream
    output logic                                 m_axis_tvalid,
    input  wire logic                            m_axis_tready,
    // is_new, wifi_total, ble_total, seen_total, stored_total, entry_valid,
    // entry_mac, entry_strength, entry_time
    output logic [rmdc_pkg::OUT_DATA_W-1:0]      m_axis_tdata,
    // entry_kind
    output logic [rmdc_pkg::OUT_USER_W-1:0]      m_axis_tuser,
    // configuration port
    input  wire logic                            psel,
    input  wire logic                            penable,
    input  wire logic                            pwrite,
    input  wire logic [rmdc_pkg::APB_AW-1:0]     paddr,
    input  wire logic [rmdc_pkg::APB_DW-1:0]     pwdata,
    output logic [rmdc_pkg::APB_DW-1:0]          prdata,
    output logic                                 pready
);
    import rmdc_pkg::*;

    logic [CAP_W-1:0] capacity_reg;
    logic             cfg_wr;
    logic             sel_capacity;
    q_head_t          head;
    logic             pop;
    logic             init_busy;
    res_t             res;

    // register file
    assign pready       = 1'b1;
    assign sel_capacity = (paddr[2] == REG_LIST_CAPACITY);
    assign cfg_wr       = psel && penable && pwrite && pready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            capacity_reg <= CAP_RESET;
        end
        else if (cfg_wr && sel_capacity)
        begin
            capacity_reg <= pwdata[CAP_W-1:0];
        end
    end

    assign prdata = sel_capacity ? APB_DW'(capacity_reg) : '0;

    // front end: accept and classify
    rmdc_front u_front (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .hold          (init_busy),
        .head          (head),
        .pop           (pop)
    );

    // back end: execute
    rmdc_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .head      (head),
        .pop       (pop),
        .init_busy (init_busy),
        .capacity  (capacity_reg),
        .out_valid (m_axis_tvalid),
        .out_ready (m_axis_tready),
        .out_res   (res)
    );

    // result packing
    assign m_axis_tdata = {res.entry_time, res.entry_strength, res.entry_mac,
                           res.entry_valid, res.stored_total, res.seen_total,
                           res.ble_total, res.wifi_total, res.is_new};
    assign m_axis_tuser = res.entry_kind;

endmodule

`default_nettype wire

@@ hdl/rmdc_front.sv @@
// ----------------------------------------------------------------------------
// rmdc_front
// accepts input items, decodes the map word and bit, queues the commands
// ----------------------------------------------------------------------------
`default_nettype none

module rmdc_front (
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    input  wire logic                           s_axis_tvalid,
    output logic                                s_axis_tready,
    // mac_addr, signal_strength, time_stamp, entry_index, zero pad
    input  wire logic [rmdc_pkg::IN_DATA_W-1:0] s_axis_tdata,
    // op, sniff_kind
    input  wire logic [rmdc_pkg::IN_USER_W-1:0] s_axis_tuser,
    input  wire logic                           hold,
    output rmdc_pkg::q_head_t                   head,
    input  wire logic                           pop
);
    import rmdc_pkg::*;

    cmd_t                q_mem_reg [QUEUE_DEPTH];
    logic [QUEUE_AW-1:0] wr_ptr_reg;
    logic [QUEUE_AW-1:0] rd_ptr_reg;
    logic [QUEUE_AW:0]   cnt_reg;
    logic [QUEUE_AW:0]   cnt_next;
    cmd_t                cmd_in;
    logic [ID_W-1:0]     dev_id;
    logic                full;
    logic                push;
    logic                do_pop;

    // classify the incoming item
    always_comb
    begin
        cmd_in.op          = op_t'(s_axis_tuser[1:0]);
        cmd_in.kind        = s_axis_tuser[3:2];
        cmd_in.mac         = s_axis_tdata[47:0];
        cmd_in.strength    = s_axis_tdata[55:48];
        cmd_in.stamp       = s_axis_tdata[87:56];
        cmd_in.idx         = s_axis_tdata[91:88];
        cmd_in.local_admin = s_axis_tdata[LOCAL_ADMIN_POS];
        // id is byte 4 low, byte 5 high
        dev_id             = {s_axis_tdata[7:0], s_axis_tdata[15:8]};
        cmd_in.word        = dev_id[BIT_AW +: MAP_AW];
        cmd_in.bit_pos     = dev_id[BIT_AW-1:0];
    end

    // queue handshake
    assign full          = (cnt_reg == (QUEUE_AW+1)'(QUEUE_DEPTH));
    assign s_axis_tready = !full && !hold;
    assign push          = s_axis_tvalid && s_axis_tready;
    assign do_pop        = pop && head.valid;
    assign head.valid    = (cnt_reg != '0);
    assign head.cmd      = q_mem_reg[rd_ptr_reg];

    always_comb
    begin
        cnt_next = cnt_reg;
        if (push && !do_pop)
        begin
            cnt_next = cnt_reg + 1'b1;
        end
        else if (!push && do_pop)
        begin
            cnt_next = cnt_reg - 1'b1;
        end
    end

    // queue pointers and fill
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            cnt_reg <= cnt_next;
            if (push)
            begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (do_pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
        end
    end

    // queue storage
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            q_mem_reg[wr_ptr_reg] <= cmd_in;
        end
    end

endmodule

`default_nettype wire

@@ hdl/rmdc_back.sv @@
// ----------------------------------------------------------------------------
// rmdc_back
// executes commands: seen map read-modify-write, map sweep, device list,
// counters and the output register
// ----------------------------------------------------------------------------
`default_nettype none

module rmdc_back (
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    input  wire rmdc_pkg::q_head_t           head,
    output logic                             pop,
    output logic                             init_busy,
    input  wire logic [rmdc_pkg::CAP_W-1:0]  capacity,
    output logic                             out_valid,
    input  wire logic                        out_ready,
    output rmdc_pkg::res_t                   out_res
);
    import rmdc_pkg::*;

    // memories
    logic [WORD_W-1:0] seen_map_mem [MAP_WORDS];
    logic [MAC_W-1:0]  list_mac_mem [LIST_DEPTH];
    logic [INFO_W-1:0] list_info_mem [LIST_DEPTH];
    logic [TIME_W-1:0] list_time_mem [LIST_DEPTH];

    // control state
    state_t            state_reg;
    state_t            state_next;
    logic [MAP_AW-1:0] sweep_addr_reg;
    logic              sweep_init_reg;
    logic [SEEN_W-1:0] seen_reg;
    logic [SEEN_W-1:0] seen_next;
    logic [TOT_W-1:0]  wifi_reg;
    logic [TOT_W-1:0]  wifi_next;
    logic [TOT_W-1:0]  ble_reg;
    logic [TOT_W-1:0]  ble_next;
    logic [CNT_W-1:0]  list_cnt_reg;
    logic [CNT_W-1:0]  list_cnt_next;
    logic              out_valid_reg;
    logic              out_valid_next;

    // payload
    cmd_t              cmd_reg;
    res_t              res_reg;
    res_t              res_next;
    res_t              out_res_reg;
    logic [WORD_W-1:0] map_q_reg;
    logic [MAC_W-1:0]  ent_mac_reg;
    logic [INFO_W-1:0] ent_info_reg;
    logic [TIME_W-1:0] ent_time_reg;

    // datapath controls
    logic              sweep_last;
    logic              out_free;
    logic              map_we;
    logic [MAP_AW-1:0] map_waddr;
    logic [WORD_W-1:0] map_wdata;
    logic              list_we;
    logic              hit;
    logic              fresh;
    logic              store;
    logic              rd_valid;
    logic [CNT_W-1:0]  cap_eff;
    logic              res_load;

    assign sweep_last = (sweep_addr_reg == MAP_AW'(MAP_WORDS - 1));
    assign out_free   = !out_valid_reg || out_ready;
    assign init_busy  = (state_reg == ST_SWEEP) && sweep_init_reg;
    assign out_valid  = out_valid_reg;
    assign out_res    = out_res_reg;

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_SWEEP:
            begin
                if (sweep_last)
                begin
                    state_next = sweep_init_reg ? ST_IDLE : ST_DONE;
                end
            end
            ST_IDLE:
            begin
                if (head.valid)
                begin
                    state_next = (head.cmd.op == OP_CLEAR_MAP) ? ST_SWEEP : ST_LOOK;
                end
            end
            ST_LOOK:
            begin
                state_next = ST_DONE;
            end
            ST_DONE:
            begin
                if (out_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // effective capacity saturates at the list depth
    always_comb
    begin
        if (int'(capacity) > LIST_DEPTH)
        begin
            cap_eff = CNT_W'(LIST_DEPTH);
        end
        else
        begin
            cap_eff = CNT_W'(capacity);
        end
    end

    // lookup decisions
    assign hit      = map_q_reg[cmd_reg.bit_pos];
    assign fresh    = (cmd_reg.op == OP_OBSERVE) && cmd_reg.local_admin && !hit;
    assign store    = fresh && (list_cnt_reg < cap_eff);
    assign rd_valid = (cmd_reg.op == OP_READ) && (int'(cmd_reg.idx) < int'(list_cnt_reg));

    // outputs and datapath
    always_comb
    begin
        pop           = 1'b0;
        map_we        = 1'b0;
        map_waddr     = cmd_reg.word;
        map_wdata     = map_q_reg | (WORD_W'(1) << cmd_reg.bit_pos);
        list_we       = 1'b0;
        seen_next     = seen_reg;
        wifi_next     = wifi_reg;
        ble_next      = ble_reg;
        list_cnt_next = list_cnt_reg;
        res_load      = 1'b0;
        unique case (state_reg)
            ST_SWEEP:
            begin
                map_we    = 1'b1;
                map_waddr = sweep_addr_reg;
                map_wdata = '0;
                res_load  = sweep_last && !sweep_init_reg;
            end
            ST_IDLE:
            begin
                pop = head.valid;
                if (head.valid && (head.cmd.op == OP_CLEAR_MAP))
                begin
                    seen_next = '0;
                end
            end
            ST_LOOK:
            begin
                res_load = 1'b1;
                if (cmd_reg.op == OP_CLEAR_LIST)
                begin
                    list_cnt_next = '0;
                end
                if (fresh)
                begin
                    map_we    = 1'b1;
                    seen_next = seen_reg + 1'b1;
                    if (cmd_reg.kind == KIND_BLE)
                    begin
                        ble_next = ble_reg + 1'b1;
                    end
                    else if (cmd_reg.kind == KIND_WIFI)
                    begin
                        wifi_next = wifi_reg + 1'b1;
                    end
                end
                if (store)
                begin
                    list_we       = 1'b1;
                    list_cnt_next = list_cnt_reg + 1'b1;
                end
            end
            ST_DONE:
            begin
            end
            default:
            begin
            end
        endcase
    end

    // result built from the counters after the item
    always_comb
    begin
        res_next.is_new         = (state_reg == ST_LOOK) && fresh;
        res_next.wifi_total     = wifi_next;
        res_next.ble_total      = ble_next;
        res_next.seen_total     = seen_next;
        res_next.stored_total   = STORED_W'(list_cnt_next);
        res_next.entry_valid    = 1'b0;
        res_next.entry_mac      = '0;
        res_next.entry_kind     = '0;
        res_next.entry_strength = '0;
        res_next.entry_time     = '0;
        if ((state_reg == ST_LOOK) && rd_valid)
        begin
            res_next.entry_valid    = 1'b1;
            res_next.entry_mac      = ent_mac_reg;
            res_next.entry_kind     = ent_info_reg[INFO_W-1:STR_W];
            res_next.entry_strength = ent_info_reg[STR_W-1:0];
            res_next.entry_time     = ent_time_reg;
        end
    end

    // output register handshake
    always_comb
    begin
        out_valid_next = out_valid_reg && !out_ready;
        if ((state_reg == ST_DONE) && out_free)
        begin
            out_valid_next = 1'b1;
        end
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_SWEEP;
            sweep_addr_reg <= '0;
            sweep_init_reg <= 1'b1;
            seen_reg       <= '0;
            wifi_reg       <= '0;
            ble_reg        <= '0;
            list_cnt_reg   <= '0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            seen_reg      <= seen_next;
            wifi_reg      <= wifi_next;
            ble_reg       <= ble_next;
            list_cnt_reg  <= list_cnt_next;
            out_valid_reg <= out_valid_next;
            if (state_reg == ST_SWEEP)
            begin
                sweep_addr_reg <= sweep_addr_reg + 1'b1;
            end
            else if ((state_reg == ST_IDLE) && head.valid)
            begin
                sweep_addr_reg <= '0;
                sweep_init_reg <= 1'b0;
            end
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (pop)
        begin
            cmd_reg <= head.cmd;
        end
        if (res_load)
        begin
            res_reg <= res_next;
        end
        if ((state_reg == ST_DONE) && out_free)
        begin
            out_res_reg <= res_reg;
        end
    end

    // seen map, read at the queue head word
    always_ff @(posedge clk)
    begin
        if (map_we)
        begin
            seen_map_mem[map_waddr] <= map_wdata;
        end
        map_q_reg <= seen_map_mem[head.cmd.word];
    end

    // device list, read at the queue head index
    always_ff @(posedge clk)
    begin
        if (list_we)
        begin
            list_mac_mem[list_cnt_reg[LIST_AW-1:0]]  <= cmd_reg.mac;
            list_info_mem[list_cnt_reg[LIST_AW-1:0]] <= {cmd_reg.kind, cmd_reg.strength};
            list_time_mem[list_cnt_reg[LIST_AW-1:0]] <= cmd_reg.stamp;
        end
        ent_mac_reg  <= list_mac_mem[LIST_AW'(head.cmd.idx)];
        ent_info_reg <= list_info_mem[LIST_AW'(head.cmd.idx)];
        ent_time_reg <= list_time_mem[LIST_AW'(head.cmd.idx)];
    end

endmodule

`default_nettype wire

@@ hdl/rmdc_checker.sv @@
// ----------------------------------------------------------------------------
// rmdc_checker
// port level checks on the result stream of the distinct counter
// ----------------------------------------------------------------------------
`default_nettype none

`include "assert_macros.svh"

module rmdc_checker (
    input wire logic                            clk,
    input wire logic                            rst_n,
    input wire logic                            s_axis_tvalid,
    input wire logic                            s_axis_tready,
    input wire logic                            m_axis_tvalid,
    input wire logic                            m_axis_tready,
    input wire logic [rmdc_pkg::OUT_DATA_W-1:0] m_axis_tdata,
    input wire logic [rmdc_pkg::OUT_USER_W-1:0] m_axis_tuser
);
    import rmdc_pkg::*;

    logic       stalled;
    logic       rd_ok;
    logic       any_in;
    logic       any_out;
    logic       new_read;
    logic       entry_clear;
    logic       stored_ok;
    logic [3:0] open_reg;
    logic [3:0] open_next;

    assign stalled     = m_axis_tvalid && !m_axis_tready;
    assign rd_ok       = m_axis_tdata[55];
    assign any_in      = s_axis_tvalid && s_axis_tready;
    assign any_out     = m_axis_tvalid && m_axis_tready;
    assign new_read    = m_axis_tdata[0] && rd_ok;
    assign entry_clear = (m_axis_tdata[143:56] == '0) && (m_axis_tuser == '0);
    assign stored_ok   = (int'(m_axis_tdata[54:50]) <= LIST_DEPTH);

    // items taken on input whose result has not been taken yet
    always_comb
    begin
        open_next = open_reg;
        if (any_in && !any_out)
        begin
            open_next = open_reg + 1'b1;
        end
        else if (!any_in && any_out)
        begin
            open_next = open_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            open_reg <= '0;
        end
        else
        begin
            open_reg <= open_next;
        end
    end

    // a stalled result keeps its payload
    `ASSERT_NEXT(a_hold_payload, clk, rst_n, stalled, m_axis_tvalid && $stable(m_axis_tdata), "stalled result changed")

    // a new id never comes with a list read
    `ASSERT_ALWAYS(a_new_no_read, clk, rst_n, !(m_axis_tvalid && new_read), "is_new with entry_valid")

    // entry fields are zero unless the read hit a stored entry
    `ASSERT_ALWAYS(a_entry_zero, clk, rst_n, !(m_axis_tvalid && !rd_ok) || entry_clear, "entry fields set")

    // stored count never passes the list depth
    `ASSERT_ALWAYS(a_stored_max, clk, rst_n, !m_axis_tvalid || stored_ok, "stored_total above list depth")

    // a result only shows while some input item is still open
    `ASSERT_ALWAYS(a_no_orphan, clk, rst_n, !m_axis_tvalid || (open_reg != '0), "result with no item open")

endmodule

bind random_mac_distinct_counter rmdc_checker u_rmdc_checker (.*);

`default_nettype wire
